// File: sv/alm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types, constants and the log-curve table builder for the ambient
// light backlight mapper.
// ----------------------------------------------------------------------------
package alm_pkg;

   localparam int TAPS_DEFAULT  = 4;
   localparam int MAX_TAPS      = 4;
   localparam int NUM_CHANNELS  = 3;

   localparam int COUNT_W       = 16;
   localparam int WEIGHT_W      = 16;
   localparam int LEVEL_PCT_W   = 7;
   localparam int LEVEL_W       = 8;
   localparam int FRAC_W        = 32;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 16;

   localparam int CURVE_DEPTH   = 1000;
   localparam int IDX_W         = $clog2(CURVE_DEPTH);
   localparam logic [IDX_W-1:0] MAX_INDEX = IDX_W'(CURVE_DEPTH - 1);
   localparam logic [63:0]      CURVE_K   = 64'd15782539;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd150;

   // fixed luma weights, Q0.16
   localparam logic [WEIGHT_W-1:0] LUMA_RED_WEIGHT   = 16'd19595;
   localparam logic [WEIGHT_W-1:0] LUMA_GREEN_WEIGHT = 16'd38470;
   localparam logic [WEIGHT_W-1:0] LUMA_BLUE_WEIGHT  = 16'd7471;

   // input commands
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_REFRESH = 1'b1;

   // channel codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STANDBY_LEVEL   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STANDBY_MODE    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPTIVE_ENABLE = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP0_WEIGHT     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP1_WEIGHT     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP2_WEIGHT     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP3_WEIGHT     = 4'd7;

   localparam logic [WEIGHT_W-1:0]    TAP_WEIGHT_RESET    = 16'd16384;
   localparam logic [LEVEL_PCT_W-1:0] ACTIVE_LEVEL_RESET  = 7'd50;
   localparam logic [LEVEL_PCT_W-1:0] STANDBY_LEVEL_RESET = 7'd10;

   typedef struct packed {
      logic [LEVEL_PCT_W-1:0]             active_level;
      logic [LEVEL_PCT_W-1:0]             standby_level;
      logic                               standby_mode;
      logic                               adaptive_enable;
      logic [MAX_TAPS-1:0][WEIGHT_W-1:0]  tap_weight;
   } cfg_type;

   typedef struct packed {
      logic       shift_in;
      logic       acc_clear;
      logic       mac_en;
      logic       luma_step;
      logic [1:0] chan;
      logic [1:0] tap;
   } mac_ctrl_type;

   typedef logic [LEVEL_W-1:0] curve_table_type [CURVE_DEPTH];

   // filter sum width: one 16x16 product per tap
   function automatic int filt_width(input int taps);
      return 2 * COUNT_W + $clog2(taps);
   endfunction

   // luma plus base, Q.32
   function automatic int acc_width(input int taps);
      return filt_width(taps) + WEIGHT_W + 2;
   endfunction

   // log2(n) in Q.32 by repeated squaring, truncating each step
   function automatic logic [63:0] log2_q32(input int unsigned n);
      int unsigned k;
      logic [63:0] m;
      logic [63:0] frac;
      k    = 0;
      frac = '0;
      for (int j = 0; j < 31; j++) begin
         if ((n >> (j + 1)) != 0) begin
            k = j + 1;
         end
      end
      m = 64'(n) << (30 - k);
      for (int b = 31; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m       = m >> 1;
            frac[b] = 1'b1;
         end
      end
      return (64'(k) << FRAC_W) | frac;
   endfunction

   // elaboration-time table of the backlight curve per per-mille index
   function automatic curve_table_type build_curve_table();
      curve_table_type tbl;
      logic [63:0] top_log;
      logic [63:0] d;
      top_log = log2_q32(CURVE_DEPTH);
      for (int i = 0; i < CURVE_DEPTH; i++) begin
         d      = top_log - log2_q32(CURVE_DEPTH - i);
         tbl[i] = LEVEL_W'((d * CURVE_K + (64'd1 << 51)) >> 52);
      end
      return tbl;
   endfunction

endpackage

// File: sv/alm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_mac
// Sample history and the shared multiply-accumulate unit that forms the
// filtered channels and the luma sum, one product per cycle.
// ----------------------------------------------------------------------------
module alm_mac
   import alm_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mac_ctrl_type                ctrl,
   input  cfg_type                     cfg,
   input  logic [COUNT_W-1:0]          red_count,
   input  logic [COUNT_W-1:0]          green_count,
   input  logic [COUNT_W-1:0]          blue_count,
   output logic [acc_width(TAPS)-1:0]  total
);

   localparam int HIST_DEPTH = NUM_CHANNELS * TAPS;
   localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
   localparam int FILT_W     = filt_width(TAPS);
   localparam int ACC_W      = acc_width(TAPS);
   localparam int PROD_W     = FILT_W + WEIGHT_W;

   logic [COUNT_W-1:0]     hist_ff [HIST_DEPTH];
   logic [FILT_W-1:0]      filt_ff;
   logic [ACC_W-1:0]       luma_ff;

   logic [HIST_IDX_W-1:0]  hist_idx;
   logic [COUNT_W-1:0]     sample;
   logic [WEIGHT_W-1:0]    luma_weight;
   logic [FILT_W-1:0]      op_a;
   logic [WEIGHT_W-1:0]    op_b;
   logic [PROD_W-1:0]      prod;
   logic [LEVEL_PCT_W-1:0] base;

   always_comb begin
      hist_idx = HIST_IDX_W'(int'(ctrl.chan) * TAPS + int'(ctrl.tap));
      sample   = hist_ff[hist_idx];
      case (ctrl.chan)
         CH_RED:   luma_weight = LUMA_RED_WEIGHT;
         CH_GREEN: luma_weight = LUMA_GREEN_WEIGHT;
         CH_BLUE:  luma_weight = LUMA_BLUE_WEIGHT;
         default:  luma_weight = '0;
      endcase
      // one multiplier serves both the filter taps and the luma weights
      op_a = ctrl.luma_step ? filt_ff : FILT_W'(sample);
      op_b = ctrl.luma_step ? luma_weight : cfg.tap_weight[ctrl.tap];
      prod = PROD_W'(op_a) * PROD_W'(op_b);
      base = cfg.standby_mode ? cfg.standby_level : cfg.active_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (ctrl.shift_in) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int t = TAPS - 1; t > 0; t--) begin
               hist_ff[c * TAPS + t] <= hist_ff[c * TAPS + t - 1];
            end
         end
         hist_ff[0]        <= red_count;
         hist_ff[TAPS]     <= green_count;
         hist_ff[2 * TAPS] <= blue_count;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc_clear) begin
         filt_ff <= '0;
         luma_ff <= ACC_W'(base) << FRAC_W;
      end else if (ctrl.mac_en) begin
         if (ctrl.luma_step) begin
            luma_ff <= luma_ff + ACC_W'(prod);
            filt_ff <= '0;
         end else begin
            filt_ff <= filt_ff + FILT_W'(prod);
         end
      end
   end

   assign total = luma_ff;

endmodule

// File: sv/alm_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_curve
// Per-mille index of the Q.32 total, saturated, and the registered lookup
// of the logarithmic backlight curve.
// ----------------------------------------------------------------------------
module alm_curve
   import alm_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                        clock,
   input  logic [acc_width(TAPS)-1:0]  total,
   output logic [LEVEL_W-1:0]          level
);

   localparam int ACC_W   = acc_width(TAPS);
   localparam int SCALE_W = ACC_W + 4;
   localparam int WHOLE_W = SCALE_W - FRAC_W;

   localparam curve_table_type CURVE_TABLE = build_curve_table();

   logic [SCALE_W-1:0] scaled;
   logic [WHOLE_W-1:0] whole;
   logic [IDX_W-1:0]   idx_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [LEVEL_W-1:0] level_ff;

   always_comb begin
      // times ten as shift and add
      scaled = (SCALE_W'(total) << 3) + (SCALE_W'(total) << 1);
      whole  = scaled[SCALE_W-1:FRAC_W];
      if (whole > WHOLE_W'(MAX_INDEX)) begin
         idx_in = MAX_INDEX;
      end else begin
         idx_in = whole[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      level_ff <= CURVE_TABLE[idx_ff];
   end

   assign level = level_ff;

endmodule

// File: sv/alm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_ctrl
// Sequencer: takes items, steps the shared multiply-accumulate unit over
// channels and taps, waits out the curve lookup and holds the result item.
// ----------------------------------------------------------------------------
module alm_ctrl
   import alm_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_cmd,
   output logic               req_stall,
   input  logic               adaptive_enable,
   input  logic [LEVEL_W-1:0] level,
   output mac_ctrl_type       ctrl,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [LEVEL_W-1:0] rsp_backlight_level
);

   localparam int TAP_CNT_W = $clog2(TAPS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MAC    = 3'd1;
   localparam logic [2:0] ST_INDEX  = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]           state_ff,     state_in;
   logic [1:0]           chan_ff,      chan_in;
   logic [TAP_CNT_W-1:0] tap_ff,       tap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   level_out_ff, level_out_in;
   logic                 last_tap;

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      tap_in       = tap_ff;
      level_out_in = level_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      last_tap     = (tap_ff == TAP_CNT_W'(TAPS));

      ctrl.shift_in  = 1'b0;
      ctrl.acc_clear = 1'b0;
      ctrl.mac_en    = 1'b0;
      // the extra step after the taps of a channel applies its luma weight
      ctrl.luma_step = (state_ff == ST_MAC) && last_tap;
      ctrl.chan      = chan_ff;
      ctrl.tap       = ctrl.luma_step ? 2'd0 : 2'(tap_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_SAMPLE && adaptive_enable) begin
                  ctrl.shift_in  = 1'b1;
                  ctrl.acc_clear = 1'b1;
                  chan_in        = CH_RED;
                  tap_in         = '0;
                  state_in       = ST_MAC;
               end else if (req_cmd == CMD_REFRESH && !adaptive_enable) begin
                  ctrl.acc_clear = 1'b1;
                  state_in       = ST_INDEX;
               end
            end
         end
         ST_MAC: begin
            ctrl.mac_en = 1'b1;
            if (last_tap) begin
               tap_in = '0;
               if (chan_ff == CH_BLUE) begin
                  state_in = ST_INDEX;
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end else begin
               tap_in = TAP_CNT_W'(tap_ff + 1'b1);
            end
         end
         ST_INDEX: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               level_out_in = level;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CH_RED;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_out_ff <= level_out_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_backlight_level = level_out_ff;

endmodule

// File: sv/ambient_light_backlight_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_backlight_mapper
// Ambient light adaptive backlight: FIR-filtered RGB sensor counts to luma,
// plus a base level, mapped through a logarithmic curve to a level 0..150.
// ----------------------------------------------------------------------------
// A sensor item taken while adaptive mode is on is shifted into the history
// and runs through one shared multiplier, one product per cycle over TAPS
// taps and a luma step for each of three channels, then through the index,
// lookup and done states. The done state waits for the result register to
// be free, and no next item is taken until the block is idle again. A
// refresh taken while adaptive mode is off skips the multiplier. Items that
// give no result are taken and leave the block idle. The next item may be
// taken while the previous result item is still held stalled.
// Configuration writes are always taken (csr_ready is tied high).
module ambient_light_backlight_mapper
   import alm_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [COUNT_W-1:0]    req_red_count,
   input  logic [COUNT_W-1:0]    req_green_count,
   input  logic [COUNT_W-1:0]    req_blue_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LEVEL_W-1:0]    rsp_backlight_level,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type                    cfg_ff;
   mac_ctrl_type               ctrl;
   logic [acc_width(TAPS)-1:0] total;
   logic [LEVEL_W-1:0]         level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level    <= ACTIVE_LEVEL_RESET;
         cfg_ff.standby_level   <= STANDBY_LEVEL_RESET;
         cfg_ff.standby_mode    <= 1'b0;
         cfg_ff.adaptive_enable <= 1'b0;
         for (int t = 0; t < MAX_TAPS; t++) begin
            cfg_ff.tap_weight[t] <= TAP_WEIGHT_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTIVE_LEVEL:    cfg_ff.active_level    <= csr_data[LEVEL_PCT_W-1:0];
            CSR_STANDBY_LEVEL:   cfg_ff.standby_level   <= csr_data[LEVEL_PCT_W-1:0];
            CSR_STANDBY_MODE:    cfg_ff.standby_mode    <= csr_data[0];
            CSR_ADAPTIVE_ENABLE: cfg_ff.adaptive_enable <= csr_data[0];
            CSR_TAP0_WEIGHT:     cfg_ff.tap_weight[0]   <= csr_data;
            CSR_TAP1_WEIGHT:     cfg_ff.tap_weight[1]   <= csr_data;
            CSR_TAP2_WEIGHT:     cfg_ff.tap_weight[2]   <= csr_data;
            CSR_TAP3_WEIGHT:     cfg_ff.tap_weight[3]   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   alm_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_cmd             (req_cmd),
      .req_stall           (req_stall),
      .adaptive_enable     (cfg_ff.adaptive_enable),
      .level               (level),
      .ctrl                (ctrl),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_backlight_level (rsp_backlight_level)
   );

   alm_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg_ff),
      .red_count   (req_red_count),
      .green_count (req_green_count),
      .blue_count  (req_blue_count),
      .total       (total)
   );

   alm_curve #(
      .TAPS (TAPS)
   ) u_curve (
      .clock (clock),
      .total (total),
      .level (level)
   );

endmodule

// File: sv/alm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_checker
// Port-level checks on the backlight mapper, bound to the top level.
// ----------------------------------------------------------------------------
module alm_checker
   import alm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [LEVEL_W-1:0] rsp_backlight_level
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_backlight_level))
      else $error("stalled result item changed");

   // the curve never exceeds its top level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_backlight_level <= LEVEL_MAX)
      else $error("backlight level out of range");

   // a new result only appears out of a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item appeared while input side was idle");

   // no result can follow an accepted item in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result item too early after accepted item");

endmodule

bind ambient_light_backlight_mapper alm_checker u_checker (.*);

// File: tb/tb_ambient_light_backlight_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ambient_light_backlight_mapper
// Self-checking bench for the ambient light backlight mapper. A directed
// script covers reset values, level extremes, ignored items and filter
// corners. Random phases with fresh register settings follow. Every result
// item is checked against its script level or a local filter, luma, log model.
// ----------------------------------------------------------------------------
module tb_ambient_light_backlight_mapper;
   import alm_pkg::*;

   localparam int TAPS           = TAPS_DEFAULT;
   localparam int DRAIN_CYCLES   = 3 * (TAPS + 1) + 3 + 12;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int HOLD_PHASE     = 3;
   localparam int PAUSE_PHASE    = 5;
   localparam int HOLD_CYCLES    = 600;
   localparam int GAP_PERCENT    = 36;

   typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  data;
      logic                   cmd;
      logic [COUNT_W-1:0]     red;
      logic [COUNT_W-1:0]     green;
      logic [COUNT_W-1:0]     blue;
      bit                     has_level;
      logic [LEVEL_W-1:0]     level;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = CMD_SAMPLE;
   logic [COUNT_W-1:0]    req_red_count = '0;
   logic [COUNT_W-1:0]    req_green_count = '0;
   logic [COUNT_W-1:0]    req_blue_count = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]    rsp_backlight_level;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   ambient_light_backlight_mapper #(.TAPS(TAPS)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_red_count       (req_red_count),
      .req_green_count     (req_green_count),
      .req_blue_count      (req_blue_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_backlight_level (rsp_backlight_level),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // shadow registers and sample history of the model
   logic [LEVEL_PCT_W-1:0] cfg_active  = ACTIVE_LEVEL_RESET;
   logic [LEVEL_PCT_W-1:0] cfg_standby = STANDBY_LEVEL_RESET;
   logic                   cfg_mode     = 1'b0;
   logic                   cfg_adaptive = 1'b0;
   logic [WEIGHT_W-1:0]    cfg_tap [MAX_TAPS];
   logic [COUNT_W-1:0]     history [NUM_CHANNELS][TAPS];

   logic [LEVEL_W-1:0] expected_levels [$];
   logic [LEVEL_W-1:0] oldest_level;
   script_row_type     script [$];
   int                 errors = 0;
   int                 sent_items = 0;
   bit                 no_gaps = 1'b0;
   bit                 hold_request = 1'b0;
   bit                 hold_done = 1'b0;
   int                 hold_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(64'd5_000_000);
      $display("Regression FAIL");
      $finish;
   end

   // log2 in Q.32, mantissa squared bit by bit with truncation
   function automatic logic [63:0] log2_fixed(input int unsigned n);
      int unsigned msb;
      logic [63:0] mant;
      logic [63:0] frac;
      msb  = $clog2(n + 1) - 1;
      mant = 64'(n) << (30 - msb);
      frac = '0;
      for (int b = 31; b >= 0; b--) begin
         mant = (mant * mant) >> 30;
         if (mant >= (64'd1 << 31)) begin
            mant    = mant >> 1;
            frac[b] = 1'b1;
         end
      end
      return (64'(msb) << 32) | frac;
   endfunction

   function automatic logic [LEVEL_W-1:0] curve_level(input int unsigned per_mille);
      logic [63:0] log_delta;
      logic [63:0] rounded;
      log_delta = log2_fixed(CURVE_DEPTH) - log2_fixed(CURVE_DEPTH - per_mille);
      rounded   = (log_delta * CURVE_K + (64'd1 << 51)) >> 52;
      return rounded[LEVEL_W-1:0];
   endfunction

   // returns 1 when the item gives a result item
   function automatic bit predict_backlight(input logic cmd, input logic [COUNT_W-1:0] red,
                                            input logic [COUNT_W-1:0] green,
                                            input logic [COUNT_W-1:0] blue,
                                            output logic [LEVEL_W-1:0] level);
      logic [COUNT_W-1:0]     counts [NUM_CHANNELS];
      logic [63:0]            luma_w [NUM_CHANNELS];
      logic [63:0]            filt;
      logic [63:0]            luma;
      logic [63:0]            total;
      logic [63:0]            per_mille;
      logic [LEVEL_PCT_W-1:0] base;
      counts[0] = red;
      counts[1] = green;
      counts[2] = blue;
      luma_w[0] = 64'(LUMA_RED_WEIGHT);
      luma_w[1] = 64'(LUMA_GREEN_WEIGHT);
      luma_w[2] = 64'(LUMA_BLUE_WEIGHT);
      level = '0;
      luma  = '0;
      base  = cfg_mode ? cfg_standby : cfg_active;
      if (cmd == CMD_REFRESH) begin
         if (cfg_adaptive) return 1'b0;
      end else begin
         if (!cfg_adaptive) return 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int t = TAPS - 1; t > 0; t--) begin
               history[c][t] = history[c][t-1];
            end
            history[c][0] = counts[c];
            filt = '0;
            for (int t = 0; t < TAPS; t++) begin
               filt += 64'(history[c][t]) * 64'(cfg_tap[t]);
            end
            luma += filt * luma_w[c];
         end
      end
      total     = luma + (64'(base) << 32);
      per_mille = (total * 10) >> 32;
      if (per_mille > 64'(MAX_INDEX)) per_mille = 64'(MAX_INDEX);
      level = curve_level(int'(per_mille));
      return 1'b1;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4, 5: return COUNT_W'($urandom_range(0, 127));
         6, 7:    return COUNT_W'($urandom_range(0, 2047));
         default: return COUNT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_level_data();
      case ($urandom_range(5))
         0:       return '0;
         1:       return CSR_DATA_W'(100);
         2:       return CSR_DATA_W'($urandom_range(0, 65535));
         default: return CSR_DATA_W'($urandom_range(0, 100));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_weight();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return TAP_WEIGHT_RESET;
         3, 4:    return CSR_DATA_W'($urandom_range(0, 65535));
         5:       return CSR_DATA_W'($urandom_range(0, 4095));
         default: return CSR_DATA_W'($urandom_range(8192, 24576));
      endcase
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row           = '{kind: ROW_WRITE, default: '0};
      row.index     = index;
      row.data      = data;
      script.push_back(row);
   endfunction

   function automatic void add_item(input logic cmd, input logic [COUNT_W-1:0] red,
                                    input logic [COUNT_W-1:0] green,
                                    input logic [COUNT_W-1:0] blue,
                                    input bit has_level, input logic [LEVEL_W-1:0] level);
      script_row_type row;
      row           = '{kind: ROW_ITEM, default: '0};
      row.cmd       = cmd;
      row.red       = red;
      row.green     = green;
      row.blue      = blue;
      row.has_level = has_level;
      row.level     = level;
      script.push_back(row);
   endfunction

   // block idle: nothing pending, plus time for an item that gives no result
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_ACTIVE_LEVEL:    cfg_active   = data[LEVEL_PCT_W-1:0];
         CSR_STANDBY_LEVEL:   cfg_standby  = data[LEVEL_PCT_W-1:0];
         CSR_STANDBY_MODE:    cfg_mode     = data[0];
         CSR_ADAPTIVE_ENABLE: cfg_adaptive = data[0];
         CSR_TAP0_WEIGHT:     cfg_tap[0]   = data;
         CSR_TAP1_WEIGHT:     cfg_tap[1]   = data;
         CSR_TAP2_WEIGHT:     cfg_tap[2]   = data;
         CSR_TAP3_WEIGHT:     cfg_tap[3]   = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drives one item, returns at the edge that takes it with valid still high
   task automatic send_item(input logic cmd, input logic [COUNT_W-1:0] red,
                            input logic [COUNT_W-1:0] green,
                            input logic [COUNT_W-1:0] blue,
                            input bit has_level, input logic [LEVEL_W-1:0] level);
      logic [LEVEL_W-1:0] predicted;
      while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_red_count   <= red;
      req_green_count <= green;
      req_blue_count  <= blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_backlight(cmd, red, green, blue, predicted)) begin
         expected_levels.push_back(has_level ? level : predicted);
      end
   endtask

   task automatic randomize_config(input bit write_all, input bit force_adaptive);
      if (write_all || $urandom_range(99) < 60) write_reg(CSR_ACTIVE_LEVEL, pick_level_data());
      if (write_all || $urandom_range(99) < 60) write_reg(CSR_STANDBY_LEVEL, pick_level_data());
      if (write_all || $urandom_range(99) < 60) begin
         write_reg(CSR_STANDBY_MODE, CSR_DATA_W'($urandom_range(0, 65535)));
      end
      write_reg(CSR_TAP0_WEIGHT, pick_weight());
      if (write_all || $urandom_range(99) < 60) write_reg(CSR_TAP1_WEIGHT, pick_weight());
      if (write_all || $urandom_range(99) < 60) write_reg(CSR_TAP2_WEIGHT, pick_weight());
      if (write_all || $urandom_range(99) < 60) write_reg(CSR_TAP3_WEIGHT, pick_weight());
      if ($urandom_range(99) < 20) begin
         // indexes past the register list must not disturb anything
         write_reg(CSR_IDX_W'($urandom_range(8, 15)), CSR_DATA_W'($urandom_range(0, 65535)));
      end
      write_reg(CSR_ADAPTIVE_ENABLE,
                CSR_DATA_W'(force_adaptive || $urandom_range(99) < 70));
   endtask

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(99) < GAP_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels.size() == 0) begin
            $error("unexpected result item: backlight_level %0d", rsp_backlight_level);
            errors++;
         end else begin
            oldest_level = expected_levels.pop_front();
            if (rsp_backlight_level !== oldest_level) begin
               $error("backlight_level: expected %0d, actual %0d",
                      oldest_level, rsp_backlight_level);
               errors++;
            end
         end
      end
   end

   initial begin
      int             phase;
      int             items;
      logic           cmd;
      script_row_type row;
      for (int t = 0; t < MAX_TAPS; t++) cfg_tap[t] = TAP_WEIGHT_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         for (int t = 0; t < TAPS; t++) history[c][t] = '0;
      end

      // reset values, adaptive off
      add_item(CMD_REFRESH, '0, '0, '0, 1'b1, 8'd15);
      add_item(CMD_SAMPLE, '1, '1, '1, 1'b0, '0);
      add_item(CMD_SAMPLE, '0, '0, '0, 1'b0, '0);
      add_write(CSR_ACTIVE_LEVEL, '0);
      add_item(CMD_REFRESH, '1, '1, '1, 1'b1, 8'd0);
      add_write(CSR_ACTIVE_LEVEL, 16'd100);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b1, LEVEL_MAX);
      // masked to 127, beyond 100 the index saturates
      add_write(CSR_ACTIVE_LEVEL, 16'hFFFF);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b1, LEVEL_MAX);
      add_write(CSR_STANDBY_MODE, 16'd1);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b0, '0);
      add_write(CSR_STANDBY_LEVEL, '0);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b1, 8'd0);
      add_write(CSR_STANDBY_LEVEL, 16'd100);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b1, LEVEL_MAX);
      add_write(4'd8, '0);
      add_write(4'd15, 16'hFFFF);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b1, LEVEL_MAX);
      add_write(CSR_STANDBY_LEVEL, 16'd37);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b0, '0);
      // adaptive on
      add_write(CSR_STANDBY_MODE, '0);
      add_write(CSR_ACTIVE_LEVEL, '0);
      add_write(CSR_ADAPTIVE_ENABLE, 16'd1);
      add_item(CMD_REFRESH, '0, '0, '0, 1'b0, '0);
      add_item(CMD_SAMPLE, '0, '0, '0, 1'b1, 8'd0);
      add_item(CMD_SAMPLE, '1, '1, '1, 1'b1, LEVEL_MAX);
      add_item(CMD_SAMPLE, 16'd20, 16'd40, 16'd60, 1'b0, '0);
      add_item(CMD_SAMPLE, 16'd5, 16'd5, 16'd5, 1'b0, '0);
      add_item(CMD_SAMPLE, 16'd1, 16'd0, 16'd0, 1'b0, '0);
      // newest tap only
      add_write(CSR_TAP0_WEIGHT, 16'hFFFF);
      add_write(CSR_TAP1_WEIGHT, '0);
      add_write(CSR_TAP2_WEIGHT, '0);
      add_write(CSR_TAP3_WEIGHT, '0);
      add_item(CMD_SAMPLE, 16'd50, 16'd50, 16'd50, 1'b0, '0);
      add_item(CMD_SAMPLE, 16'd99, 16'd99, 16'd99, 1'b0, '0);
      add_item(CMD_SAMPLE, '0, '0, '0, 1'b1, 8'd0);
      // oldest tap only
      add_write(CSR_TAP0_WEIGHT, '0);
      add_write(CSR_TAP3_WEIGHT, 16'hFFFF);
      add_write(CSR_ACTIVE_LEVEL, 16'd25);
      add_item(CMD_SAMPLE, 16'hFFFF, '0, '0, 1'b0, '0);
      add_item(CMD_SAMPLE, 16'd10, 16'd20, 16'd30, 1'b0, '0);
      add_item(CMD_SAMPLE, '0, 16'd7, '0, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < script.size(); r++) begin
         row = script[r];
         if (row.kind == ROW_WRITE) begin
            if (r == 0 || script[r-1].kind != ROW_WRITE) settle();
            write_reg(row.index, row.data);
         end else begin
            send_item(row.cmd, row.red, row.green, row.blue, row.has_level, row.level);
         end
      end

      phase = 0;
      while (sent_items < RANDOM_ITEMS) begin
         settle();
         randomize_config(phase == 0, phase == HOLD_PHASE);
         no_gaps <= (phase >= 6 && phase <= 8);
         if (phase == HOLD_PHASE) hold_request <= 1'b1;
         items = $urandom_range(30, 70);
         for (int i = 0; i < items; i++) begin
            if (phase == PAUSE_PHASE && i == items / 2) begin
               req_valid <= 1'b0;
               while (expected_levels.size() != 0) @(posedge clock);
               @(posedge clock);
            end
            // mostly items that the current mode acts on
            if (cfg_adaptive) cmd = ($urandom_range(99) < 85) ? CMD_SAMPLE : CMD_REFRESH;
            else              cmd = ($urandom_range(99) < 80) ? CMD_REFRESH : CMD_SAMPLE;
            send_item(cmd, pick_count(), pick_count(), pick_count(), 1'b0, '0);
            sent_items++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
